// ===== rtl/core/lru_block_cache_directory_assert.svh =====
// Assertion macros for the cache directory checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LRU_BLOCK_CACHE_DIRECTORY_ASSERT_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBCD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbcd check failed");

// The consequent must hold in the cycle after the antecedent.
`define LBCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbcd check failed");

`endif

// ===== rtl/core/lbcd_pkg.sv =====
// Shared constants, types and codes of the LRU block cache directory.
// No dependencies; every other file of the block but the assertion header imports this package.
package lbcd_pkg;

    localparam int NUM_CACHES        = 2;
    localparam int ENTRIES_PER_CACHE = 5;
    localparam int BLOCK_BITS        = 24;

    localparam int BLOCK_IN_W  = 24;
    localparam int SEL_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 3;
    localparam int STAMP_W     = 32;

    localparam int CACHE_IDX_W = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
    localparam int ENTRY_IDX_W = (ENTRIES_PER_CACHE > 1) ? $clog2(ENTRIES_PER_CACHE) : 1;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 2'd0,
        ST_MISS   = 2'd1,
        ST_BYPASS = 2'd2,
        ST_NULL   = 2'd3
    } lbcd_status_t;

    typedef enum logic [0:0] {
        S_IDLE   = 1'b0,
        S_LOOKUP = 1'b1
    } lbcd_state_t;

    typedef logic [BLOCK_BITS-1:0]  lbcd_tag_t;
    typedef logic [STAMP_W-1:0]     lbcd_stamp_t;
    typedef logic [ENTRY_IDX_W-1:0] lbcd_entry_idx_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;
        logic commit;
    } lbcd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic rsp_busy;
    } lbcd_stat_t;

endpackage

// ===== rtl/core/lbcd_if.sv =====
// Valid/ready channel interfaces for requests and responses of the directory.
// Depends on lbcd_pkg for field widths.
interface lbcd_req_if
    import lbcd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BLOCK_IN_W-1:0] block_number;
    logic [SEL_W-1:0]      cache_select;

    modport source (output valid, output block_number, output cache_select, input ready);
    modport sink   (input valid, input block_number, input cache_select, output ready);
endinterface

interface lbcd_rsp_if
    import lbcd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== rtl/core/lbcd_ctrl.sv =====
// Controller of the cache directory: sequences request capture and commit.
// Depends on lbcd_pkg for the state type and the command and status structs.
module lbcd_ctrl
    import lbcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output lbcd_cmd_t  cmd,
    input  lbcd_stat_t stat
);

    lbcd_state_t state_reg;
    lbcd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        cmd.load_req = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // Results go out only when the output register can take a beat.
                if (!stat.rsp_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lbcd_datapath.sv =====
// Datapath of the cache directory: request register, tag and stamp store,
// parallel tag match, parallel LRU victim pick, access counter, output register.
// Depends on lbcd_pkg.
module lbcd_datapath
    import lbcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [BLOCK_IN_W-1:0] block_number,
    input  logic [SEL_W-1:0]      cache_select,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output logic [STATUS_W-1:0]   rsp_status,
    output logic [SLOT_W-1:0]     rsp_slot,
    input  lbcd_cmd_t             cmd,
    output lbcd_stat_t            stat
);

    lbcd_tag_t        req_blk_reg;
    logic [SEL_W-1:0] req_sel_reg;

    lbcd_tag_t   tags_reg   [NUM_CACHES][ENTRIES_PER_CACHE];
    lbcd_stamp_t stamps_reg [NUM_CACHES][ENTRIES_PER_CACHE];
    lbcd_stamp_t counter_reg;
    lbcd_stamp_t counter_next;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    lbcd_status_t        rsp_status_reg;
    lbcd_status_t        rsp_status_next;
    logic [SLOT_W-1:0]   rsp_slot_reg;
    logic [SLOT_W-1:0]   rsp_slot_next;

    logic [CACHE_IDX_W-1:0]       cidx;
    lbcd_tag_t                    lane_tag   [ENTRIES_PER_CACHE];
    lbcd_stamp_t                  lane_stamp [ENTRIES_PER_CACHE];
    logic [ENTRIES_PER_CACHE-1:0] hit_vec;
    logic [ENTRIES_PER_CACHE-1:0] vic_vec;
    lbcd_entry_idx_t              hit_idx;
    lbcd_entry_idx_t              vic_idx;
    lbcd_entry_idx_t              use_idx;
    logic                         is_null;
    logic                         is_bypass;
    logic                         do_update;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_blk_reg <= BLOCK_BITS'(block_number);
            req_sel_reg <= cache_select;
        end
    end

    assign cidx      = req_sel_reg[CACHE_IDX_W-1:0];
    assign is_null   = (req_blk_reg == '0);
    assign is_bypass = ({1'b0, req_sel_reg} >= (SEL_W + 1)'(NUM_CACHES));
    assign do_update = cmd.commit && !is_null && !is_bypass;

    always_comb
    begin
        for (int e = 0; e < ENTRIES_PER_CACHE; e++)
        begin
            lane_tag[e]   = tags_reg[cidx][e];
            lane_stamp[e] = stamps_reg[cidx][e];
            hit_vec[e]    = (lane_tag[e] == req_blk_reg);
        end
    end

    // An entry is the victim when its stamp is strictly below every lower
    // entry and no higher than every later one, so exactly one lane wins.
    always_comb
    begin
        for (int i = 0; i < ENTRIES_PER_CACHE; i++)
        begin
            vic_vec[i] = 1'b1;
            for (int j = 0; j < ENTRIES_PER_CACHE; j++)
            begin
                if ((j < i) && !(lane_stamp[i] < lane_stamp[j]))
                begin
                    vic_vec[i] = 1'b0;
                end
                if ((j > i) && (lane_stamp[j] < lane_stamp[i]))
                begin
                    vic_vec[i] = 1'b0;
                end
            end
        end
    end

    // Lowest set lane wins in both encoders.
    always_comb
    begin
        hit_idx = '0;
        vic_idx = '0;
        for (int e = ENTRIES_PER_CACHE - 1; e >= 0; e--)
        begin
            if (hit_vec[e])
            begin
                hit_idx = ENTRY_IDX_W'(e);
            end
            if (vic_vec[e])
            begin
                vic_idx = ENTRY_IDX_W'(e);
            end
        end
    end

    assign use_idx      = (|hit_vec) ? hit_idx : vic_idx;
    assign counter_next = (counter_reg == STAMP_MAX) ? counter_reg : counter_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            for (int c = 0; c < NUM_CACHES; c++)
            begin
                for (int e = 0; e < ENTRIES_PER_CACHE; e++)
                begin
                    tags_reg[c][e]   <= '0;
                    stamps_reg[c][e] <= '0;
                end
            end
        end
        else if (do_update)
        begin
            counter_reg                <= counter_next;
            tags_reg[cidx][use_idx]    <= req_blk_reg;
            stamps_reg[cidx][use_idx]  <= counter_next;
        end
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
            if (is_null)
            begin
                rsp_status_next = ST_NULL;
                rsp_slot_next   = '0;
            end
            else if (is_bypass)
            begin
                rsp_status_next = ST_BYPASS;
                rsp_slot_next   = '0;
            end
            else
            begin
                rsp_status_next = (|hit_vec) ? ST_HIT : ST_MISS;
                // Indexes beyond the slot field wrap modulo its range.
                rsp_slot_next   = SLOT_W'(use_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign rsp_status    = rsp_status_reg;
    assign rsp_slot      = rsp_slot_reg;
    assign stat.rsp_busy = rsp_valid_reg && !rsp_ready;

endmodule

// ===== rtl/core/lru_block_cache_directory.sv =====
// Channel   Dir  Beat contents
// req       in   block_number[23:0], cache_select[1:0]
// rsp       out  status[1:0], slot[2:0]
//
// Each request is captured, then the lookup state does the tag match,
// the victim pick and the tag and stamp write-back, which must finish before
// the next request is looked up. The result sits in an output register, so
// a new request is taken while the previous beat waits on rsp; a lookup holds
// only while that register is still full. Reset clears all tags, stamps and
// the access counter at once; the block takes requests from the first cycle.
// Depends on lbcd_pkg, lbcd_if, lbcd_ctrl and lbcd_datapath.
module lru_block_cache_directory
    import lbcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lbcd_req_if.sink          req,
    lbcd_rsp_if.source        rsp
);

    lbcd_cmd_t  cmd;
    lbcd_stat_t stat;

    lbcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lbcd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .block_number (req.block_number),
        .cache_select (req.cache_select),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .rsp_status   (rsp.status),
        .rsp_slot     (rsp.slot),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== rtl/core/lbcd_checker.sv =====
// Port-level checks of the cache directory, bound to the top level.
// Depends on lbcd_pkg and lru_block_cache_directory_assert.svh.
`include "lru_block_cache_directory_assert.svh"

module lbcd_checker
    import lbcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic [STATUS_W-1:0] rsp_status,
    input  logic [SLOT_W-1:0]   rsp_slot
);

    logic rsp_uncached;
    logic rsp_stalled;

    assign rsp_uncached = (rsp_status == ST_NULL) || (rsp_status == ST_BYPASS);
    assign rsp_stalled  = rsp_valid && !rsp_ready;

    // A request occupies the lookup state, so no beat is taken right after one.
    `LBCD_ASSERT_NEXT(a_no_back_to_back, req_valid && req_ready, !req_ready)

    // Rejected and bypassed requests never name an entry.
    `LBCD_ASSERT_SAME(a_slot_zero_uncached, rsp_valid && rsp_uncached, rsp_slot == '0)

    // A reported entry lies inside one cache.
    `LBCD_ASSERT_SAME(a_slot_in_range, rsp_valid, int'(rsp_slot) < ENTRIES_PER_CACHE)

    `LBCD_ASSERT_NEXT(a_rsp_hold, rsp_stalled, rsp_valid && $stable({rsp_status, rsp_slot}))

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.slot)
);

// ===== tb/tb_lru_block_cache_directory.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lru_block_cache_directory: directed and random requests go through
// the valid/ready channels, and every response is compared with a local directory model.
// Depends on lbcd_pkg, lbcd_if and the block itself.
module tb_lru_block_cache_directory
    import lbcd_pkg::*;
;
    typedef struct {
        logic [BLOCK_IN_W-1:0] blk;
        logic [SEL_W-1:0]      sel;
        int unsigned           gap;
    } dir_request_t;

    typedef struct {
        lbcd_status_t      status;
        logic [SLOT_W-1:0] slot;
    } dir_result_t;

    logic clk;
    logic rst_n;

    lbcd_req_if req_ch ();
    lbcd_rsp_if rsp_ch ();

    lru_block_cache_directory dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the directory contents.
    lbcd_tag_t   dir_tags   [NUM_CACHES][ENTRIES_PER_CACHE];
    lbcd_stamp_t dir_stamps [NUM_CACHES][ENTRIES_PER_CACHE];
    lbcd_stamp_t dir_clock;

    dir_request_t req_pending[$];
    dir_result_t  dir_expect[$];

    int unsigned idle_left;
    int unsigned stall_left;
    int unsigned cycles;
    int unsigned mismatches;
    int unsigned orphans;
    int unsigned n_hit;
    int unsigned n_miss;
    int unsigned n_bypass;
    int unsigned n_null;

    // Looks one request up and updates the directory copy as the block should.
    function automatic dir_result_t lookup_block(input logic [BLOCK_IN_W-1:0] blk_in,
                                                 input logic [SEL_W-1:0] sel);
        dir_result_t r;
        lbcd_tag_t   blk;
        int          c;
        int          way;
        bit          found;
        blk    = lbcd_tag_t'(blk_in);
        c      = int'(sel);
        found  = 1'b0;
        way    = 0;
        r.slot = '0;
        if (blk == '0) begin
            r.status = ST_NULL;
        end
        else if (c >= NUM_CACHES) begin
            r.status = ST_BYPASS;
        end
        else begin
            for (int i = 0; i < ENTRIES_PER_CACHE; i++) begin
                if (!found && dir_tags[c][i] == blk) begin
                    found = 1'b1;
                    way   = i;
                end
            end
            if (found) begin
                r.status = ST_HIT;
            end
            else begin
                // Oldest stamp loses; a strict compare keeps ties on the lowest index.
                for (int i = 1; i < ENTRIES_PER_CACHE; i++) begin
                    if (dir_stamps[c][i] < dir_stamps[c][way])
                        way = i;
                end
                r.status = ST_MISS;
            end
            if (dir_clock != STAMP_MAX)
                dir_clock = dir_clock + 1'b1;
            dir_stamps[c][way] = dir_clock;
            dir_tags[c][way]   = blk;
            r.slot             = SLOT_W'(way);
        end
        return r;
    endfunction

    function automatic int unsigned idle_length();
        if ($urandom_range(99, 0) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic int unsigned sender_gap(input bit calm);
        if (calm || $urandom_range(99, 0) < 50)
            return 0;
        return idle_length();
    endfunction

    task automatic add_req(input logic [BLOCK_IN_W-1:0] blk, input logic [SEL_W-1:0] sel);
        dir_request_t q;
        q.blk = blk;
        q.sel = sel;
        q.gap = sender_gap(1'b0);
        req_pending.push_back(q);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: a beat stays up until taken, then the item's gap follows.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.block_number <= '0;
            req_ch.cache_select <= '0;
            idle_left           <= 0;
            // The directory copy starts empty, as the block does after reset.
            dir_clock = '0;
            for (int c = 0; c < NUM_CACHES; c++)
                for (int i = 0; i < ENTRIES_PER_CACHE; i++)
                begin
                    dir_tags[c][i]   = '0;
                    dir_stamps[c][i] = '0;
                end
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                dir_expect.push_back(lookup_block(req_ch.block_number, req_ch.cache_select));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (idle_left != 0)
                begin
                    req_ch.valid <= 1'b0;
                    idle_left    <= idle_left - 1;
                end
                else if (req_pending.size() != 0)
                begin
                    dir_request_t q;
                    q = req_pending.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.block_number <= q.blk;
                    req_ch.cache_select <= q.sel;
                    idle_left           <= q.gap;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and ready generator; no stall starts in one window of four.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            cycles       <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (dir_expect.size() == 0)
                begin
                    orphans++;
                    if (mismatches + orphans <= 10)
                        $display("[%0t] response with nothing outstanding: status %0d slot %0d",
                                 $realtime, rsp_ch.status, rsp_ch.slot);
                end
                else
                begin
                    dir_result_t e;
                    e = dir_expect.pop_front();
                    case (e.status)
                        ST_HIT:    n_hit++;
                        ST_MISS:   n_miss++;
                        ST_BYPASS: n_bypass++;
                        default:   n_null++;
                    endcase
                    if (rsp_ch.status !== e.status || rsp_ch.slot !== e.slot)
                    begin
                        mismatches++;
                        if (mismatches + orphans <= 10)
                            $display("[%0t] expected %s slot %0d, got status %0d slot %0d",
                                     $realtime, e.status.name(), e.slot, rsp_ch.status,
                                     rsp_ch.slot);
                    end
                end
            end
            if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ((cycles / 300) % 4 != 3 && $urandom_range(99, 0) < 25)
                    stall_left <= idle_length();
            end
        end
    end

    initial
    begin
        logic [BLOCK_IN_W-1:0] hot [8];
        logic [BLOCK_IN_W-1:0] blk;
        logic [SEL_W-1:0]      sel;
        logic [SEL_W-1:0]      last_cache;
        dir_request_t          q;
        int unsigned           r;
        int unsigned           leftover;

        rst_n      = 1'b0;
        last_cache = SEL_W'(NUM_CACHES - 1);

        // Null block wins over bypass; bypass leaves the directory alone.
        add_req('0, '0);
        add_req('0, '1);
        add_req('1, '1);
        add_req(BLOCK_IN_W'(1), SEL_W'(2));
        // Fill the first cache from reset, where every stamp ties.
        add_req('1, '0);
        add_req(BLOCK_IN_W'(1), '0);
        add_req(BLOCK_IN_W'(24'h800000), '0);
        add_req(BLOCK_IN_W'(24'h555555), '0);
        add_req(BLOCK_IN_W'(24'hAAAAAA), '0);
        add_req(BLOCK_IN_W'(1), '0);
        add_req('1, '0);
        add_req('1, '1);
        add_req(BLOCK_IN_W'(24'h123456), '0);
        add_req(BLOCK_IN_W'(24'h7FFFFF), '0);
        add_req(BLOCK_IN_W'(24'hAAAAAA), '0);
        // The other cache keeps its own copy of the same block.
        add_req('1, last_cache);
        add_req(BLOCK_IN_W'(1), last_cache);
        add_req('1, last_cache);
        add_req('0, '0);
        add_req(BLOCK_IN_W'(24'h800000), '0);

        // Mostly a small hot set so hits and evictions alternate, with some cold blocks.
        for (int k = 0; k < 8; k++)
            hot[k] = BLOCK_IN_W'($urandom_range(32'hFFFFFF, 1));
        for (int n = 0; n < 500; n++)
        begin
            if (n % 40 == 39)
                hot[$urandom_range(7, 0)] = BLOCK_IN_W'($urandom_range(32'hFFFFFF, 1));
            r = $urandom_range(99, 0);
            if (r < 5)
                blk = '0;
            else if (r < 80)
                blk = hot[$urandom_range(7, 0)];
            else
                blk = BLOCK_IN_W'($urandom);
            if ($urandom_range(99, 0) < 75)
                sel = SEL_W'($urandom_range(NUM_CACHES - 1, 0));
            else
                sel = SEL_W'($urandom);
            q.blk = blk;
            q.sel = sel;
            q.gap = sender_gap((n / 60) % 3 == 1);
            req_pending.push_back(q);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (req_pending.size() != 0 || req_ch.valid || dir_expect.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        leftover = dir_expect.size();
        $display("responses checked: %0d hits, %0d misses, %0d bypassed, %0d null blocks",
                 n_hit, n_miss, n_bypass, n_null);
        $display("%0d wrong, %0d unexpected, %0d still outstanding",
                 mismatches, orphans, leftover);
        if (mismatches == 0 && orphans == 0 && leftover == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d responses outstanding", dir_expect.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
